[hw/rtl/pslu_pkg.sv]
// Shared constants and types of the parameter-set locator.
package pslu_pkg;

    localparam int POS_BITS_DEF = 16;
    localparam int OUT_W        = 16;
    localparam int WIN_LEN      = 5;

    // Tracking registers, one slot each in a packed array
    localparam int TRK_N     = 5;
    localparam int TRK_HDR   = 0;
    localparam int TRK_SPS_B = 1;
    localparam int TRK_SPS_L = 2;
    localparam int TRK_PPS_B = 3;
    localparam int TRK_PPS_L = 4;

    localparam logic [7:0] NAL_TYPE_MASK = 8'h1f;
    localparam logic [4:0] NAL_SPS       = 5'h07;
    localparam logic [4:0] NAL_PPS       = 5'h08;
    localparam logic [4:0] NAL_IDR       = 5'h05;
    localparam logic [7:0] NAL_SEI_BYTE  = 8'h06;

    localparam logic [7:0] SC_ZERO = 8'h00;
    localparam logic [7:0] SC_ONE  = 8'h01;

    typedef logic [WIN_LEN-1:0][7:0] t_window;

endpackage

[hw/rtl/h264_parameter_set_locator_unit.sv]
// H.264 Annex B SPS/PPS locator: top level with input and result registers.
//
// Input stream: one buffer byte per item on s_axis_tdata, s_axis_tlast on
// the final byte of the buffer. Output stream: one result item per buffer,
// given for the last byte: header length, SPS begin/length and PPS
// begin/length in m_axis_tdata, the found flag in m_axis_tuser.
// Throughput is one byte per cycle unless a last byte waits as described
// below; the scan of each byte is a window compare feeding the tracking
// registers, done in the single stage between the input register and the
// state/result registers. The last byte passes the input register and then
// the result register, whose valid flag drives m_axis_tvalid.
// If the result register is still full when another last byte reaches the
// scan stage, that byte waits and s_axis_tready drops until the receiver
// takes the pending result; ordinary bytes keep flowing while no last byte waits.
// Reset (synchronous, active low) clears the window, position counter,
// tracking registers and both valid flags. After each last byte the scan
// state returns to its reset value for the next buffer.
module h264_parameter_set_locator_unit
    import pslu_pkg::*;
#(
    parameter int POS_BITS = POS_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [7:0]           s_axis_tdata,   // data_byte
    input  logic                 s_axis_tlast,   // last_byte
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // header_length, sps_begin, sps_length, pps_begin, pps_length
    output logic [5*OUT_W-1:0]   m_axis_tdata,
    output logic [0:0]           m_axis_tuser    // found
);

    logic                            r_in_valid;
    logic [7:0]                      r_in_byte;
    logic                            r_in_last;
    logic                            r_out_valid;
    logic [5*OUT_W-1:0]              r_out_data;
    logic                            r_out_found;

    logic                            advance;
    logic [TRK_N-1:0][POS_BITS-1:0]  trk;
    logic [TRK_N-1:0][31:0]          trk_ext;
    logic [5*OUT_W-1:0]              n_out_data;
    logic                            n_out_found;

    assign advance = r_in_valid && (!r_in_last || !r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    pslu_core #(.POS_BITS(POS_BITS)) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (advance),
        .i_byte  (r_in_byte),
        .i_last  (r_in_last),
        .o_trk   (trk)
    );

    for (genvar g = 0; g < TRK_N; g++) begin : g_ext
        assign trk_ext[g] = 32'(trk[g]);
    end

    assign n_out_data = {trk_ext[TRK_PPS_L][OUT_W-1:0], trk_ext[TRK_PPS_B][OUT_W-1:0],
                         trk_ext[TRK_SPS_L][OUT_W-1:0], trk_ext[TRK_SPS_B][OUT_W-1:0],
                         trk_ext[TRK_HDR][OUT_W-1:0]};
    assign n_out_found = (trk[TRK_SPS_L] != '0) && (trk[TRK_PPS_L] != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_last) begin
            r_out_data  <= n_out_data;
            r_out_found <= n_out_found;
        end
    end

    assign m_axis_tvalid   = r_out_valid;
    assign m_axis_tdata    = r_out_data;
    assign m_axis_tuser[0] = r_out_found;

endmodule

[hw/rtl/pslu_judge.sv]
// Start code match and NAL header classification for one scan position.
module pslu_judge
    import pslu_pkg::*;
#(
    parameter int POS_BITS = POS_BITS_DEF
) (
    input  logic                            i_en,
    input  t_window                         i_win,   // index 0 = byte at i_pos
    input  logic [POS_BITS-1:0]             i_pos,
    input  logic [2:0]                      i_skip,
    input  logic [TRK_N-1:0][POS_BITS-1:0]  i_trk,
    output logic [2:0]                      o_skip,
    output logic [TRK_N-1:0][POS_BITS-1:0]  o_trk
);

    logic                code3;
    logic                code4;
    logic [2:0]          code_len;
    logic [7:0]          hdr_byte;
    logic [4:0]          nal_type;
    logic [POS_BITS:0]   sum_code;
    logic [POS_BITS:0]   sum_one;
    logic [POS_BITS-1:0] after_code;
    logic [POS_BITS-1:0] after_one;
    logic [POS_BITS-1:0] sps_diff;
    logic [POS_BITS-1:0] pps_diff;

    assign code3 = (i_win[0] == SC_ZERO) && (i_win[1] == SC_ZERO) && (i_win[2] == SC_ONE);
    assign code4 = !code3 && (i_win[0] == SC_ZERO) && (i_win[1] == SC_ZERO)
                   && (i_win[2] == SC_ZERO) && (i_win[3] == SC_ONE);
    assign code_len = code3 ? 3'd3 : 3'd4;
    assign hdr_byte = code3 ? i_win[3] : i_win[4];
    assign nal_type = 5'(hdr_byte & NAL_TYPE_MASK);

    // saturating offsets past the start code / past this byte
    assign sum_code   = {1'b0, i_pos} + (POS_BITS+1)'(code_len);
    assign sum_one    = {1'b0, i_pos} + (POS_BITS+1)'(1);
    assign after_code = sum_code[POS_BITS] ? '1 : sum_code[POS_BITS-1:0];
    assign after_one  = sum_one[POS_BITS]  ? '1 : sum_one[POS_BITS-1:0];

    assign sps_diff = (i_pos >= i_trk[TRK_SPS_B]) ? (i_pos - i_trk[TRK_SPS_B]) : '0;
    assign pps_diff = (i_pos >= i_trk[TRK_PPS_B]) ? (i_pos - i_trk[TRK_PPS_B]) : '0;

    always_comb begin
        o_skip = i_skip;
        o_trk  = i_trk;
        if (i_en) begin
            if (i_skip != 3'd0) begin
                o_skip = i_skip - 3'd1;
            end else if (code3 || code4) begin
                o_skip = code_len - 3'd1;
                if (nal_type == NAL_SPS) begin
                    o_trk[TRK_SPS_B] = after_code;
                    o_trk[TRK_HDR]   = after_code;
                end else if (nal_type == NAL_PPS) begin
                    if ((i_trk[TRK_SPS_L] == '0) && (i_trk[TRK_SPS_B] != '0)) begin
                        o_trk[TRK_SPS_L] = sps_diff;
                    end
                    o_trk[TRK_PPS_B] = after_code;
                    o_trk[TRK_HDR]   = after_code;
                end else if ((hdr_byte == NAL_SEI_BYTE) || (nal_type == NAL_IDR)) begin
                    if ((i_trk[TRK_PPS_L] == '0) && (i_trk[TRK_PPS_B] != '0)) begin
                        o_trk[TRK_PPS_L] = pps_diff;
                    end
                    o_trk[TRK_HDR] = after_code;
                end else if (i_trk[TRK_HDR] == '0) begin
                    o_trk[TRK_HDR] = after_code;
                end
            end else begin
                o_skip = 3'd0;
                if (i_trk[TRK_HDR] == '0) begin
                    o_trk[TRK_HDR] = after_one;
                end
            end
        end
    end

endmodule

[hw/rtl/pslu_core.sv]
// Byte window, position counter and tracking registers of the scanner.
module pslu_core
    import pslu_pkg::*;
#(
    parameter int POS_BITS = POS_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  logic [7:0]                      i_byte,
    input  logic                            i_last,
    output logic [TRK_N-1:0][POS_BITS-1:0]  o_trk
);

    t_window                         r_win;
    logic [POS_BITS-1:0]             r_cnt;
    logic [2:0]                      r_skip;
    logic [TRK_N-1:0][POS_BITS-1:0]  r_trk;

    t_window                         win_new;
    t_window                         win_tail;
    logic                            en_a;
    logic                            en_b;
    logic [POS_BITS-1:0]             pos_a;
    logic [POS_BITS-1:0]             pos_b;
    logic [2:0]                      skip_a;
    logic [2:0]                      skip_b;
    logic [TRK_N-1:0][POS_BITS-1:0]  trk_a;
    logic [TRK_N-1:0][POS_BITS-1:0]  trk_b;
    logic [POS_BITS-1:0]             n_cnt;

    assign win_new  = {i_byte, r_win[WIN_LEN-1:1]};
    // flush position on the last byte; a header past the end reads as zero
    assign win_tail = {SC_ZERO, win_new[WIN_LEN-1:1]};

    assign en_a  = i_en && (r_cnt >= POS_BITS'(4));
    assign en_b  = i_en && i_last && (r_cnt >= POS_BITS'(3));
    assign pos_a = r_cnt - POS_BITS'(4);
    assign pos_b = r_cnt - POS_BITS'(3);
    assign n_cnt = (r_cnt == '1) ? r_cnt : (r_cnt + POS_BITS'(1));

    pslu_judge #(.POS_BITS(POS_BITS)) u_judge_a (
        .i_en   (en_a),
        .i_win  (win_new),
        .i_pos  (pos_a),
        .i_skip (r_skip),
        .i_trk  (r_trk),
        .o_skip (skip_a),
        .o_trk  (trk_a)
    );

    pslu_judge #(.POS_BITS(POS_BITS)) u_judge_b (
        .i_en   (en_b),
        .i_win  (win_tail),
        .i_pos  (pos_b),
        .i_skip (skip_a),
        .i_trk  (trk_a),
        .o_skip (skip_b),
        .o_trk  (trk_b)
    );

    assign o_trk = trk_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win  <= '0;
            r_cnt  <= '0;
            r_skip <= '0;
            r_trk  <= '0;
        end else if (i_en) begin
            if (i_last) begin
                r_win  <= '0;
                r_cnt  <= '0;
                r_skip <= '0;
                r_trk  <= '0;
            end else begin
                r_win  <= win_new;
                r_cnt  <= n_cnt;
                r_skip <= skip_b;
                r_trk  <= trk_b;
            end
        end
    end

endmodule

[hw/rtl/pslu_checker.sv]
// Port-level checks of the parameter-set locator, bound to the top level.
module pslu_checker
    import pslu_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                s_axis_tvalid,
    input logic                s_axis_tready,
    input logic [7:0]          s_axis_tdata,
    input logic                s_axis_tlast,
    input logic                m_axis_tvalid,
    input logic                m_axis_tready,
    input logic [5*OUT_W-1:0]  m_axis_tdata,
    input logic [0:0]          m_axis_tuser
);

    // reset empties both stages
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && s_axis_tready)
        else $error("not empty after reset");

    // input stalls only behind a pending result that is not being taken
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled without a blocked result");

    // a fresh result follows a last byte through the two registers
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready && s_axis_tlast, 2))
        else $error("result without a last byte");

    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
        else $error("stalled result changed");

endmodule

bind h264_parameter_set_locator_unit pslu_checker u_pslu_checker (.*);
